>>> rtl/drive_command_framer_crc16_assert.svh
// Assertion macros shared by the framer modules.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef DRIVE_COMMAND_FRAMER_CRC16_ASSERT_SVH
`define DRIVE_COMMAND_FRAMER_CRC16_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DCF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define DCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/dcf_pkg.sv
// Shared types, codes and the CRC-16 byte update for the command framer.
// No dependencies; the framer modules and the testbench import this package.
package dcf_pkg;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_DATA  = 2'd2;

	localparam logic [7:0]  SYNC_BYTE      = 8'hA5;
	localparam logic [7:0]  CMD_READ_CODE  = 8'h01;
	localparam logic [7:0]  CMD_WRITE_CODE = 8'h02;
	localparam logic [15:0] CRC_POLY       = 16'h1021;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_READ,
		KIND_WRITE,
		KIND_DATA,
		KIND_DATA_LAST
	} cmd_kind_t;

	// One classified request as it travels from the front to the back.
	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] node;
		logic [7:0] index;
		logic [7:0] offset;
		logic [7:0] count;
		logic [7:0] data;
	} entry_t;

	// Direct-form CRC-16 update by one byte, MSB first. Over a whole message
	// this equals the augmented form followed by two zero bytes.
	function automatic logic [15:0] crc16_feed(input logic [15:0] crc,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> rtl/dcf_if.sv
// Valid/ready channels of the framer: command requests in, link bytes out.
// Depends on nothing.
interface dcf_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] node_address;
	logic [7:0] frame_index;
	logic [7:0] frame_offset;
	logic [7:0] word_count;
	logic [7:0] data_byte;

	modport source (output valid, opcode, node_address, frame_index, frame_offset,
		word_count, data_byte, input ready);
	modport sink (input valid, opcode, node_address, frame_index, frame_offset,
		word_count, data_byte, output ready);
endinterface

interface dcf_link_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       end_of_frame;
	logic       end_of_run;

	modport source (output valid, out_byte, end_of_frame, end_of_run, input ready);
	modport sink (input valid, out_byte, end_of_frame, end_of_run, output ready);
endinterface

>>> rtl/dcf_front.sv
// Front end: accepts requests, tracks the open write frame and classifies.
// Depends on dcf_pkg and dcf_cmd_if.
module dcf_front #(
	parameter int MAX_DATA_WORDS = 27
) (
	input  logic            clk,
	input  logic            arst_n,
	dcf_cmd_if.sink         cmd,
	input  logic            full,
	output logic            push,
	output dcf_pkg::entry_t entry
);
	import dcf_pkg::*;

	localparam int         BL_W   = $clog2(2 * MAX_DATA_WORDS + 1);
	localparam logic [7:0] MAX_WC = 8'(MAX_DATA_WORDS);

	logic            frame_open_q;
	logic [BL_W-1:0] bytes_left_q;
	logic            accept;
	logic            last_data;
	logic [7:0]      wc_clamped;

	assign cmd.ready = !full;
	assign accept    = cmd.valid && !full;
	assign last_data = (bytes_left_q == BL_W'(1));
	assign wc_clamped = (cmd.word_count > MAX_WC) ? MAX_WC : cmd.word_count;

	always_comb begin
		push         = 1'b0;
		entry.kind   = KIND_DATA;
		entry.node   = cmd.node_address;
		entry.index  = cmd.frame_index;
		entry.offset = cmd.frame_offset;
		entry.count  = cmd.word_count;
		entry.data   = cmd.data_byte;
		unique case (cmd.opcode)
			OP_READ: begin
				push       = accept;
				entry.kind = KIND_READ;
			end
			OP_WRITE: begin
				push        = accept;
				entry.kind  = KIND_WRITE;
				entry.count = wc_clamped;
			end
			OP_DATA: begin
				// Data outside an open write frame is dropped here.
				push       = accept && frame_open_q;
				entry.kind = last_data ? KIND_DATA_LAST : KIND_DATA;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			bytes_left_q <= '0;
		end else if (accept) begin
			priority if (cmd.opcode == OP_READ) begin
				frame_open_q <= 1'b0;
				bytes_left_q <= '0;
			end else if (cmd.opcode == OP_WRITE) begin
				frame_open_q <= (wc_clamped != 8'd0);
				bytes_left_q <= BL_W'({wc_clamped, 1'b0});
			end else if (cmd.opcode == OP_DATA && frame_open_q) begin
				bytes_left_q <= bytes_left_q - BL_W'(1);
				if (last_data) begin
					frame_open_q <= 1'b0;
				end
			end else begin
				// Stray data and the unused opcode leave the frame state alone.
				frame_open_q <= frame_open_q;
			end
		end
	end

endmodule

>>> rtl/dcf_queue.sv
// Short request queue between the front and back ends.
// Depends on dcf_pkg and the assertion macro header.
module dcf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dcf_pkg::entry_t entry,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output dcf_pkg::entry_t head
);
	import dcf_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`include "drive_command_framer_crc16_assert.svh"

	`DCF_ASSERT_NOW(a_no_push_full, push, !full, "queue written while full")
	`DCF_ASSERT_NOW(a_no_pop_empty, pop, !empty, "queue read while empty")

endmodule

>>> rtl/dcf_back.sv
// Back end: walks each queued request through its output bytes and CRC.
// Depends on dcf_pkg, dcf_link_if and the assertion macro header.
module dcf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  dcf_pkg::entry_t head,
	output logic            pop,
	dcf_link_if.source      link
);
	import dcf_pkg::*;

	localparam logic [3:0] STEP_CRC_HI   = 4'd6;
	localparam logic [3:0] STEP_CRC_LO   = 4'd7;
	localparam logic [3:0] STEP_ZERO_END = 4'd9;
	localparam logic [3:0] STEP_DATA_END = 4'd2;

	logic [3:0]  step_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        eof_q;
	logic        eor_q;

	logic        gen;
	logic        is_hdr;
	logic [3:0]  last_step;
	logic        at_last;
	logic [7:0]  byte_nx;
	logic        eof_nx;
	logic        crc_upd;
	logic [15:0] crc_base;

	assign gen    = !empty && (!out_valid_q || link.ready);
	assign is_hdr = (head.kind == KIND_READ) || (head.kind == KIND_WRITE);

	always_comb begin
		unique case (head.kind)
			KIND_READ:      last_step = STEP_CRC_LO;
			KIND_WRITE:     last_step = (head.count == 8'd0) ? STEP_ZERO_END : STEP_CRC_LO;
			KIND_DATA:      last_step = 4'd0;
			KIND_DATA_LAST: last_step = STEP_DATA_END;
			default:        last_step = 4'd0;
		endcase
	end

	assign at_last = (step_q == last_step);
	assign pop     = gen && at_last;

	// The header CRC always starts from zero on the sync byte.
	assign crc_base = (is_hdr && step_q == 4'd0) ? 16'h0000 : crc_q;

	always_comb begin
		byte_nx = 8'h00;
		eof_nx  = 1'b0;
		crc_upd = 1'b0;
		if (is_hdr) begin
			unique case (step_q)
				4'd0:        begin byte_nx = SYNC_BYTE;    crc_upd = 1'b1; end
				4'd1:        begin byte_nx = head.node;    crc_upd = 1'b1; end
				4'd2: begin
					byte_nx = (head.kind == KIND_WRITE) ? CMD_WRITE_CODE : CMD_READ_CODE;
					crc_upd = 1'b1;
				end
				4'd3:        begin byte_nx = head.index;   crc_upd = 1'b1; end
				4'd4:        begin byte_nx = head.offset;  crc_upd = 1'b1; end
				4'd5:        begin byte_nx = head.count;   crc_upd = 1'b1; end
				STEP_CRC_HI: byte_nx = crc_q[15:8];
				STEP_CRC_LO: byte_nx = crc_q[7:0];
				default:     byte_nx = 8'h00;
			endcase
			// A write with data keeps its frame open past the header CRC.
			eof_nx = at_last && ((head.kind == KIND_READ) || (head.count == 8'd0));
		end else begin
			unique case (step_q)
				4'd0: begin
					byte_nx = head.data;
					crc_upd = 1'b1;
				end
				4'd1:    byte_nx = crc_q[15:8];
				default: byte_nx = crc_q[7:0];
			endcase
			eof_nx = (head.kind == KIND_DATA_LAST) && at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			crc_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			eof_q       <= 1'b0;
			eor_q       <= 1'b0;
		end else if (gen) begin
			out_valid_q <= 1'b1;
			out_byte_q  <= byte_nx;
			eof_q       <= eof_nx;
			eor_q       <= at_last;
			step_q      <= at_last ? 4'd0 : step_q + 4'd1;
			// The data field CRC restarts once the header CRC is out.
			if (is_hdr && at_last) begin
				crc_q <= 16'h0000;
			end else if (crc_upd) begin
				crc_q <= crc16_feed(crc_base, byte_nx);
			end
		end else if (link.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign link.valid        = out_valid_q;
	assign link.out_byte     = out_byte_q;
	assign link.end_of_frame = eof_q;
	assign link.end_of_run   = eor_q;

	`include "drive_command_framer_crc16_assert.svh"

	`DCF_ASSERT_NOW(a_eof_ends_run, out_valid_q && eof_q, eor_q,
		"frame end not marked as end of run")
	`DCF_ASSERT_NOW(a_step_has_head, step_q != 4'd0, !empty,
		"request left the queue mid sequence")
	`DCF_ASSERT_NOW(a_step_range, 1'b1, step_q <= STEP_ZERO_END,
		"sequence step out of range")

endmodule

>>> rtl/drive_command_framer_crc16.sv
// Servo drive command framer with CRC-16 over header and data field.
// Requests pass a four-entry queue and the output register on the way to the link.
// Data bytes sustain one request per cycle while the link is ready; headers and the last
// data byte hold the back end through their CRC bytes while the queue absorbs requests.
// Asynchronous reset empties the queue and output register and closes any frame.
module drive_command_framer_crc16 #(
	parameter int MAX_DATA_WORDS = 27
) (
	input  logic       clk,
	input  logic       arst_n,
	dcf_cmd_if.sink    cmd,
	dcf_link_if.source link
);
	import dcf_pkg::*;

	logic   push;
	logic   pop;
	logic   full;
	logic   empty;
	entry_t entry;
	entry_t head;

	dcf_front #(
		.MAX_DATA_WORDS(MAX_DATA_WORDS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.full  (full),
		.push  (push),
		.entry (entry)
	);

	dcf_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.entry (entry),
		.pop   (pop),
		.full  (full),
		.empty (empty),
		.head  (head)
	);

	dcf_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.empty (empty),
		.head  (head),
		.pop   (pop),
		.link  (link)
	);

endmodule

>>> tb/sv/tb_drive_command_framer_crc16.sv
// Self-checking testbench for the drive command framer: directed and random command
// requests go in, and every link byte is checked against a CRC-16 framing predictor.
// Depends on dcf_pkg, the dcf_cmd_if / dcf_link_if channels and the framer RTL.
`timescale 1ns / 1ps

module tb_drive_command_framer_crc16;
	import dcf_pkg::*;

	localparam int FRAME_WORD_LIMIT = 27;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int PAYLOAD_TARGET = 500;
	localparam int DRAIN_CYCLES = 24;
	localparam int WATCHDOG_NS = 1_000_000;
	localparam int LONG_HOLD_CYCLES = 200;

	typedef struct {
		logic [1:0] op;
		logic [7:0] node;
		logic [7:0] index;
		logic [7:0] offset;
		logic [7:0] count;
		logic [7:0] data;
	} cmd_req_t;

	typedef struct {
		logic [7:0] value;
		logic       eof;
		logic       eor;
	} link_byte_t;

	// A typed row gives the number of link bytes and their leading values.
	typedef struct {
		logic [1:0]      op;
		logic [7:0]      node;
		logic [7:0]      index;
		logic [7:0]      offset;
		logic [7:0]      count;
		logic [7:0]      data;
		int              n_typed;
		logic [0:5][7:0] head;
	} directed_row_t;

	typedef enum int {
		SINK_OPEN,
		SINK_BUSY,
		SINK_SLOW,
		SINK_CRAWL,
		SINK_HOLD
	} sink_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	dcf_cmd_if  cmd_bus ();
	dcf_link_if link_bus ();

	drive_command_framer_crc16 #(
		.MAX_DATA_WORDS(FRAME_WORD_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.link(link_bus)
	);

	always #1 clk = ~clk;

	link_byte_t pending_link_bytes[$];
	int         link_mismatches = 0;
	int         table_mismatches = 0;
	int         burst_left = 0;
	int         payload_items = 0;
	logic       random_started = 1'b0;

	// Framer state as the predictor sees it.
	logic [15:0] data_crc = '0;
	logic [7:0]  data_left = '0;
	logic        write_open = 1'b0;

	// Augmented CRC-16: the byte is shifted in MSB first behind the register.
	function automatic logic [15:0] crc_shift_in(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		logic        top;
		r = acc;
		for (int k = 7; k >= 0; k--) begin
			top = r[15];
			r = {r[14:0], b[k]};
			if (top)
				r = r ^ CRC_POLY;
		end
		return r;
	endfunction

	function automatic logic [15:0] crc_close(input logic [15:0] acc);
		return crc_shift_in(crc_shift_in(acc, 8'h00), 8'h00);
	endfunction

	function automatic void queue_link_byte(input logic [7:0] value, input logic eof);
		link_byte_t lb;
		lb.value = value;
		lb.eof = eof;
		lb.eor = 1'b0;
		pending_link_bytes.push_back(lb);
	endfunction

	// Appends the link bytes that one accepted request produces.
	function automatic void predict_frame_bytes(input cmd_req_t r);
		logic [7:0]  hdr [6];
		logic [15:0] crc;
		logic [7:0]  wc;
		int          first;
		first = pending_link_bytes.size();
		if (r.op == OP_READ || r.op == OP_WRITE) begin
			wc = r.count;
			if (r.op == OP_WRITE && wc > FRAME_WORD_LIMIT)
				wc = 8'(FRAME_WORD_LIMIT);
			hdr[0] = SYNC_BYTE;
			hdr[1] = r.node;
			hdr[2] = (r.op == OP_WRITE) ? CMD_WRITE_CODE : CMD_READ_CODE;
			hdr[3] = r.index;
			hdr[4] = r.offset;
			hdr[5] = wc;
			crc = '0;
			for (int i = 0; i < 6; i++) begin
				crc = crc_shift_in(crc, hdr[i]);
				queue_link_byte(hdr[i], 1'b0);
			end
			crc = crc_close(crc);
			queue_link_byte(crc[15:8], 1'b0);
			write_open = 1'b0;
			data_left = '0;
			data_crc = '0;
			if (r.op == OP_READ) begin
				queue_link_byte(crc[7:0], 1'b1);
			end else if (wc == 8'd0) begin
				// An empty data field still carries its CRC, which is zero.
				queue_link_byte(crc[7:0], 1'b0);
				queue_link_byte(8'h00, 1'b0);
				queue_link_byte(8'h00, 1'b1);
			end else begin
				queue_link_byte(crc[7:0], 1'b0);
				write_open = 1'b1;
				data_left = 8'(wc * 2);
			end
		end else if (r.op == OP_DATA && write_open) begin
			data_crc = crc_shift_in(data_crc, r.data);
			queue_link_byte(r.data, 1'b0);
			if (data_left != 8'd0)
				data_left = data_left - 8'd1;
			if (data_left == 8'd0) begin
				crc = crc_close(data_crc);
				queue_link_byte(crc[15:8], 1'b0);
				queue_link_byte(crc[7:0], 1'b1);
				data_crc = crc;
				write_open = 1'b0;
			end
		end
		if (pending_link_bytes.size() > first)
			pending_link_bytes[pending_link_bytes.size() - 1].eor = 1'b1;
	endfunction

	function automatic cmd_req_t random_req(input logic [1:0] op);
		cmd_req_t r;
		r.op = op;
		r.node = 8'($urandom);
		r.index = 8'($urandom);
		r.offset = 8'($urandom);
		r.count = 8'($urandom);
		r.data = 8'($urandom);
		return r;
	endfunction

	// Called just after a falling edge; returns just after the falling edge that
	// follows acceptance, with valid still high so the next request can follow.
	task automatic offer(input cmd_req_t r, input int n_typed, input logic [0:5][7:0] head);
		int gap;
		int base;
		int head_len;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
			if (gap > 0) begin
				cmd_bus.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		cmd_bus.opcode = r.op;
		cmd_bus.node_address = r.node;
		cmd_bus.frame_index = r.index;
		cmd_bus.frame_offset = r.offset;
		cmd_bus.word_count = r.count;
		cmd_bus.data_byte = r.data;
		cmd_bus.valid = 1'b1;
		do
			@(posedge clk);
		while (cmd_bus.ready !== 1'b1);
		base = pending_link_bytes.size();
		predict_frame_bytes(r);
		if (n_typed >= 0) begin
			if (pending_link_bytes.size() - base != n_typed) begin
				$error("result count expected %0d actual %0d", n_typed,
					pending_link_bytes.size() - base);
				table_mismatches++;
			end else begin
				head_len = (r.op == OP_DATA) ? 1 : 6;
				for (int k = 0; k < n_typed && k < head_len; k++)
					pending_link_bytes[base + k].value = head[k];
			end
		end
		@(negedge clk);
	endtask

	always @(posedge clk) begin : link_check
		link_byte_t want;
		if (arst_n && link_bus.valid === 1'b1 && link_bus.ready === 1'b1) begin
			if (pending_link_bytes.size() == 0) begin
				$error("unexpected link byte %02h", link_bus.out_byte);
				link_mismatches++;
			end else begin
				want = pending_link_bytes.pop_front();
				if (link_bus.out_byte !== want.value) begin
					$error("out_byte expected %02h actual %02h", want.value, link_bus.out_byte);
					link_mismatches++;
				end
				if (link_bus.end_of_frame !== want.eof) begin
					$error("end_of_frame expected %0b actual %0b", want.eof,
						link_bus.end_of_frame);
					link_mismatches++;
				end
				if (link_bus.end_of_run !== want.eor) begin
					$error("end_of_run expected %0b actual %0b", want.eor, link_bus.end_of_run);
					link_mismatches++;
				end
			end
		end
	end

	// Link receiver: stretches of different stall patterns, and one long hold-off
	// once random traffic has started so that the input side backs up.
	initial begin : link_sink
		sink_mode_t mode;
		int         span;
		int         pick;
		logic       hold_done;
		link_bus.ready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			pick = $urandom_range(0, 9);
			mode = (pick < 3) ? SINK_OPEN : (pick < 7) ? SINK_BUSY
				: (pick < 9) ? SINK_SLOW : SINK_CRAWL;
			span = $urandom_range(16, 160);
			if (random_started && !hold_done) begin
				mode = SINK_HOLD;
				span = LONG_HOLD_CYCLES;
				hold_done = 1'b1;
			end
			repeat (span) begin
				@(negedge clk);
				case (mode)
					SINK_OPEN: link_bus.ready = 1'b1;
					SINK_BUSY: link_bus.ready = ($urandom_range(0, 3) != 0);
					SINK_SLOW: link_bus.ready = ($urandom_range(0, 1) != 0);
					SINK_CRAWL: link_bus.ready = ($urandom_range(0, 4) == 0);
					default: link_bus.ready = 1'b0;
				endcase
			end
		end
	end

	initial begin : stimulus
		directed_row_t rows [25];
		cmd_req_t      r;
		int            words;
		int            cut;
		int            pick;
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.opcode = OP_READ;
		cmd_bus.node_address = '0;
		cmd_bus.frame_index = '0;
		cmd_bus.frame_offset = '0;
		cmd_bus.word_count = '0;
		cmd_bus.data_byte = '0;

		// Stray data and the undefined opcode first, straight out of reset.
		rows[0] = '{OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 0, 48'h0};
		rows[1] = '{OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 48'h0};
		rows[2] = '{OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8, 48'hA5_00_01_00_00_00};
		rows[3] = '{OP_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8, 48'hA5_FF_01_FF_FF_FF};
		rows[4] = '{OP_WRITE, 8'h5A, 8'h3C, 8'hC3, 8'h00, 8'h00, 10, 48'hA5_5A_02_3C_C3_00};
		rows[5] = '{OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h77, 0, 48'h0};
		rows[6] = '{OP_WRITE, 8'h01, 8'h80, 8'h7F, 8'h01, 8'h00, 8, 48'hA5_01_02_80_7F_01};
		rows[7] = '{OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1, 48'h00_00_00_00_00_00};
		rows[8] = '{OP_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 48'h0};
		rows[9] = '{OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 3, 48'hFF_00_00_00_00_00};
		rows[10] = '{OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h12, 0, 48'h0};
		// Word counts above the limit are clamped in the header of a write only.
		rows[11] = '{OP_WRITE, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8, 48'hA5_FF_02_00_FF_1B};
		rows[12] = '{OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h81, 1, 48'h81_00_00_00_00_00};
		rows[13] = '{OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7E, 1, 48'h7E_00_00_00_00_00};
		rows[14] = '{OP_WRITE, 8'h33, 8'hCC, 8'h0F, 8'h1C, 8'h00, 8, 48'hA5_33_02_CC_0F_1B};
		rows[15] = '{OP_READ, 8'h10, 8'h20, 8'h40, 8'h1C, 8'h00, 8, 48'hA5_10_01_20_40_1C};
		rows[16] = '{OP_WRITE, 8'h0A, 8'h0B, 8'h0C, 8'h1B, 8'h00, 8, 48'hA5_0A_02_0B_0C_1B};
		rows[17] = '{OP_WRITE, 8'h0D, 8'hE1, 8'h96, 8'h02, 8'h00, -1, 48'h0};
		rows[18] = '{OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA, -1, 48'h0};
		rows[19] = '{OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h55, -1, 48'h0};
		rows[20] = '{OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'hF0, -1, 48'h0};
		rows[21] = '{OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0F, -1, 48'h0};
		rows[22] = '{OP_WRITE, 8'h42, 8'h24, 8'h18, 8'h01, 8'h00, -1, 48'h0};
		rows[23] = '{OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3C, -1, 48'h0};
		rows[24] = '{OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC3, -1, 48'h0};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			r.op = rows[i].op;
			r.node = rows[i].node;
			r.index = rows[i].index;
			r.offset = rows[i].offset;
			r.count = rows[i].count;
			r.data = rows[i].data;
			offer(r, rows[i].n_typed, rows[i].head);
		end

		// Mostly complete write frames with random content; the rest is reads,
		// abandoned frames, stray data and undefined opcodes.
		random_started = 1'b1;
		while (payload_items < PAYLOAD_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				r = random_req(OP_WRITE);
				case ($urandom_range(0, 9))
					0: r.count = 8'($urandom);
					1: r.count = 8'($urandom_range(7, 30));
					default: r.count = 8'($urandom_range(0, 4));
				endcase
				offer(r, -1, '0);
				payload_items++;
				words = (r.count > FRAME_WORD_LIMIT) ? FRAME_WORD_LIMIT : int'(r.count);
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2 * words) : 2 * words;
				for (int k = 0; k < cut; k++) begin
					if ($urandom_range(0, 29) == 0)
						offer(random_req(OP_UNUSED), -1, '0);
					offer(random_req(OP_DATA), -1, '0);
					payload_items++;
				end
			end else if (pick < 80) begin
				offer(random_req(OP_READ), -1, '0);
				payload_items++;
			end else if (pick < 90) begin
				offer(random_req(OP_DATA), -1, '0);
			end else begin
				offer(random_req(OP_UNUSED), -1, '0);
			end
		end
		cmd_bus.valid = 1'b0;

		while (pending_link_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (link_mismatches == 0 && table_mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : watchdog
		#(WATCHDOG_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
